[hw/rtl/tcw_pkg.sv]
package tcw_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'h00;

  localparam logic [COLOR_W-1:0] DEF_FG_RST = 4'hf;
  localparam logic [COLOR_W-1:0] DEF_BG_RST = 4'h0;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_BG = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL,
    ST_HOLD
  } state_t;

endpackage

[hw/rtl/tcw_if.sv]
interface tcw_in_if
  import tcw_pkg::*;
  ;
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [CHAR_W-1:0]   character;
  logic                use_position;
  logic [ROW_W-1:0]    row;
  logic [COL_W-1:0]    col;
  logic [COLOR_W-1:0]  fg;
  logic [COLOR_W-1:0]  bg;

  modport source (output valid, op, character, use_position, row, col, fg, bg,
                  input ready);
  modport sink   (input valid, op, character, use_position, row, col, fg, bg,
                  output ready);
endinterface

interface tcw_out_if
  import tcw_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic               scrolled;
  logic [CHAR_W-1:0]  cell_char;
  logic [ATTR_W-1:0]  cell_attr;

  modport source (output valid, cursor_row, cursor_col, scrolled, cell_char, cell_attr,
                  input ready);
  modport sink   (input valid, cursor_row, cursor_col, scrolled, cell_char, cell_attr,
                  output ready);
endinterface

[hw/rtl/tcw_cell_ram.sv]
module tcw_cell_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/text_console_writer_top.sv]
// Channel  Direction  Payload
// in_ch    sink       op, character, use_position, row, col, fg, bg
// out_ch   source     cursor_row, cursor_col, scrolled, cell_char, cell_attr
// cfg_*    write      cfg_index selects default_fg (0) or default_bg (1)
//
// Put: accept, then one write to the cell RAM. Read: accept, then the registered RAM read.
// Clear: one cell written per cycle.
// A put that scrolls: the single RAM port pair moves one cell
// a cycle, then blanks the last row.
// After reset a clearing pass over every cell runs before in_ch.ready rises.
// A finished item waits in the output register; only a second finished item stalls the block.
module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tcw_in_if.sink               in_ch,
  tcw_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  localparam int NCELLS = ROWS * COLUMNS;
  localparam int AW     = $clog2(NCELLS);
  localparam int RW     = $clog2(ROWS);
  localparam int CW     = $clog2(COLUMNS);

  localparam logic [AW-1:0] LAST_CELL      = AW'(NCELLS - 1);
  localparam logic [AW-1:0] LAST_ROW_START = AW'(NCELLS - COLUMNS);
  localparam logic [AW-1:0] FIRST_SRC      = AW'(COLUMNS);

  state_t              state_r, state_nxt;
  logic [COLOR_W-1:0]  def_fg_r, def_bg_r;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;

  op_t                 it_op_r, it_op_nxt;
  logic [CHAR_W-1:0]   it_char_r, it_char_nxt;
  logic [ATTR_W-1:0]   it_attr_r, it_attr_nxt;
  logic [RW-1:0]       it_row_r, it_row_nxt;
  logic [CW-1:0]       it_col_r, it_col_nxt;

  logic [AW-1:0]       sw_addr_r, sw_addr_nxt;
  logic [CELL_W-1:0]   fill_data_r, fill_data_nxt;
  logic                fill_emit_r, fill_emit_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]       wr_addr_r, wr_addr_nxt;

  logic                res_scr_r, res_scr_nxt;
  logic [CHAR_W-1:0]   res_char_r, res_char_nxt;
  logic [ATTR_W-1:0]   res_attr_r, res_attr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic                out_scr_r, out_scr_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [ATTR_W-1:0]   out_attr_r, out_attr_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata, mem_rdata;

  logic [RW-1:0]       pos_row;
  logic [CW-1:0]       pos_col;
  logic [AW-1:0]       it_addr;
  logic [ATTR_W-1:0]   def_attr, put_attr;
  logic [RW:0]         row_inc;
  logic [CW:0]         col_inc;
  logic                accept, slot_free;
  logic                emit, emit_scr;
  logic [CHAR_W-1:0]   emit_char;
  logic [ATTR_W-1:0]   emit_attr;

  tcw_cell_ram #(.DEPTH(NCELLS)) u_cell_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign accept    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign def_attr  = {def_bg_r, def_fg_r};
  assign put_attr  = (it_attr_r == '0) ? def_attr : it_attr_r;
  assign it_addr   = AW'(int'(it_row_r) * COLUMNS + int'(it_col_r));
  assign row_inc   = {1'b0, it_row_r} + 1'b1;
  assign col_inc   = {1'b0, it_col_r} + 1'b1;

  // clamp a given position, else take the cursor
  always_comb begin
    if (in_ch.use_position) begin
      if (int'(in_ch.row) > ROWS - 1) begin
        pos_row = RW'(ROWS - 1);
      end else begin
        pos_row = RW'(in_ch.row);
      end
      if (int'(in_ch.col) > COLUMNS - 1) begin
        pos_col = CW'(COLUMNS - 1);
      end else begin
        pos_col = CW'(in_ch.col);
      end
    end else begin
      pos_row = cur_row_r;
      pos_col = cur_col_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    it_op_nxt     = it_op_r;
    it_char_nxt   = it_char_r;
    it_attr_nxt   = it_attr_r;
    it_row_nxt    = it_row_r;
    it_col_nxt    = it_col_r;
    sw_addr_nxt   = sw_addr_r;
    fill_data_nxt = fill_data_r;
    fill_emit_nxt = fill_emit_r;
    wr_pend_nxt   = wr_pend_r;
    wr_addr_nxt   = wr_addr_r;
    res_scr_nxt   = res_scr_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    mem_we        = 1'b0;
    mem_waddr     = it_addr;
    mem_wdata     = {put_attr, it_char_r};
    mem_raddr     = sw_addr_r;
    emit          = 1'b0;
    emit_scr      = 1'b0;
    emit_char     = CHAR_NULL;
    emit_attr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          it_op_nxt   = in_ch.op;
          it_char_nxt = in_ch.character;
          it_attr_nxt = {in_ch.bg, in_ch.fg};
          it_row_nxt  = pos_row;
          it_col_nxt  = pos_col;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        mem_raddr = it_addr;
        unique case (it_op_r)
          OP_PUT: begin
            mem_we = (it_char_r != CHAR_NEWLINE);
            if ((it_char_r == CHAR_NEWLINE) || (col_inc == (CW+1)'(COLUMNS))) begin
              cur_col_nxt = '0;
              if (row_inc == (RW+1)'(ROWS)) begin
                // past the last row: shift rows up, then blank the last row
                cur_row_nxt = RW'(ROWS - 1);
                sw_addr_nxt = FIRST_SRC;
                wr_pend_nxt = 1'b0;
                state_nxt   = ST_SCROLL;
              end else begin
                cur_row_nxt = row_inc[RW-1:0];
                emit        = 1'b1;
              end
            end else begin
              cur_row_nxt = it_row_r;
              cur_col_nxt = col_inc[CW-1:0];
              emit        = 1'b1;
            end
          end
          OP_CLEAR: begin
            cur_row_nxt   = '0;
            cur_col_nxt   = '0;
            sw_addr_nxt   = '0;
            fill_data_nxt = {def_attr, CHAR_SPACE};
            fill_emit_nxt = 1'b1;
            res_scr_nxt   = 1'b0;
            state_nxt     = ST_FILL;
          end
          OP_READ: begin
            state_nxt = ST_RDATA;
          end
          OP_NONE: begin
            emit = 1'b1;
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      ST_RDATA: begin
        emit      = 1'b1;
        emit_char = mem_rdata[CHAR_W-1:0];
        emit_attr = mem_rdata[CELL_W-1:CHAR_W];
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell read last cycle one row up
        mem_we      = wr_pend_r;
        mem_waddr   = wr_addr_r;
        mem_wdata   = mem_rdata;
        mem_raddr   = sw_addr_r;
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = sw_addr_r - FIRST_SRC;
        sw_addr_nxt = sw_addr_r + 1'b1;
        if (sw_addr_r == LAST_CELL) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        mem_we        = wr_pend_r;
        mem_waddr     = wr_addr_r;
        mem_wdata     = mem_rdata;
        wr_pend_nxt   = 1'b0;
        sw_addr_nxt   = LAST_ROW_START;
        fill_data_nxt = {def_attr, CHAR_NULL};
        fill_emit_nxt = 1'b1;
        res_scr_nxt   = 1'b1;
        state_nxt     = ST_FILL;
      end
      ST_FILL: begin
        mem_we      = 1'b1;
        mem_waddr   = sw_addr_r;
        mem_wdata   = fill_data_r;
        sw_addr_nxt = sw_addr_r + 1'b1;
        if (sw_addr_r == LAST_CELL) begin
          if (fill_emit_r) begin
            emit     = 1'b1;
            emit_scr = res_scr_r;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_HOLD: begin
        emit      = 1'b1;
        emit_scr  = res_scr_r;
        emit_char = res_char_r;
        emit_attr = res_attr_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result to the output register, or hold it until the slot drains
    if (emit) begin
      if (slot_free) begin
        state_nxt = ST_IDLE;
      end else begin
        res_scr_nxt  = emit_scr;
        res_char_nxt = emit_char;
        res_attr_nxt = emit_attr;
        state_nxt    = ST_HOLD;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    if (emit && slot_free) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = ROW_W'(cur_row_nxt);
      out_col_nxt   = COL_W'(cur_col_nxt);
      out_scr_nxt   = emit_scr;
      out_char_nxt  = emit_char;
      out_attr_nxt  = emit_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      sw_addr_r   <= '0;
      fill_data_r <= {DEF_BG_RST, DEF_FG_RST, CHAR_SPACE};
      fill_emit_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      def_fg_r    <= DEF_FG_RST;
      def_bg_r    <= DEF_BG_RST;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      sw_addr_r   <= sw_addr_nxt;
      fill_data_r <= fill_data_nxt;
      fill_emit_r <= fill_emit_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_DEFAULT_FG) begin
          def_fg_r <= cfg_wdata;
        end else if (cfg_index == CFG_DEFAULT_BG) begin
          def_bg_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    it_op_r    <= it_op_nxt;
    it_char_r  <= it_char_nxt;
    it_attr_r  <= it_attr_nxt;
    it_row_r   <= it_row_nxt;
    it_col_r   <= it_col_nxt;
    wr_addr_r  <= wr_addr_nxt;
    res_scr_r  <= res_scr_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_scr_r  <= out_scr_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.scrolled   = out_scr_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;

`ifndef NO_ASSERTIONS
  a_scroll_write_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL && mem_we) |-> (mem_waddr < mem_raddr))
    else $error("scroll write overtook its read");

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor left the grid");

  a_scroll_homes_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |-> (out_col_r == '0 && out_row_r == ROW_W'(ROWS - 1)))
    else $error("scrolled item does not report the last row start");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) != ST_IDLE))
    else $error("result without an item in work");
`endif

endmodule

[test/text_console_writer_top_tb.sv]
module text_console_writer_top_tb;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int NCELLS  = COLUMNS * ROWS;

  typedef struct packed {
    op_t                op;
    logic [CHAR_W-1:0]  character;
    logic               use_position;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } console_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } console_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COLOR_W-1:0]   cfg_wdata;

  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_writer_top #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the console: cell store, cursor and default colors
  logic [CELL_W-1:0]  screen [NCELLS];
  int                 cursor_pos;
  logic [COLOR_W-1:0] dflt_fg;
  logic [COLOR_W-1:0] dflt_bg;

  console_result_t pending_results [$];

  int error_count;
  int result_count;
  int hold_off_cycles;
  bit sender_gaps;
  bit stall_enable;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void blank_shadow();
    for (int i = 0; i < NCELLS; i++) screen[i] = {dflt_bg, dflt_fg, CHAR_SPACE};
    cursor_pos = 0;
  endfunction

  function automatic void scroll_screen();
    for (int i = 0; i < NCELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    for (int i = NCELLS - COLUMNS; i < NCELLS; i++) screen[i] = {dflt_bg, dflt_fg, CHAR_NULL};
  endfunction

  function automatic int target_cell(console_cmd_t c);
    int r;
    int k;
    if (!c.use_position) return cursor_pos;
    r = (c.row > ROWS - 1) ? ROWS - 1 : c.row;
    k = (c.col > COLUMNS - 1) ? COLUMNS - 1 : c.col;
    return r * COLUMNS + k;
  endfunction

  function automatic console_result_t apply_command(console_cmd_t c);
    console_result_t r;
    int pos;
    int nxt;
    logic [ATTR_W-1:0] attr;
    r = '0;
    case (c.op)
      OP_PUT: begin
        pos = target_cell(c);
        if (c.character == CHAR_NEWLINE) begin
          nxt = (pos / COLUMNS + 1) * COLUMNS;
        end else begin
          attr = {c.bg, c.fg};
          if (attr == '0) attr = {dflt_bg, dflt_fg};
          screen[pos] = {attr, c.character};
          nxt = pos + 1;
        end
        // run off the bottom: scroll and park at the last row
        if (nxt >= NCELLS) begin
          scroll_screen();
          nxt = NCELLS - COLUMNS;
          r.scrolled = 1'b1;
        end
        cursor_pos = nxt;
      end
      OP_CLEAR: blank_shadow();
      OP_READ: {r.cell_attr, r.cell_char} = screen[target_cell(c)];
      default: ;
    endcase
    r.cursor_row = ROW_W'(cursor_pos / COLUMNS);
    r.cursor_col = COL_W'(cursor_pos % COLUMNS);
    return r;
  endfunction

  function automatic console_cmd_t make_cmd(op_t op, int ch, bit use_pos, int row, int col,
                                            int fg, int bg);
    console_cmd_t c;
    c.op           = op;
    c.character    = CHAR_W'(ch);
    c.use_position = use_pos;
    c.row          = ROW_W'(row);
    c.col          = COL_W'(col);
    c.fg           = COLOR_W'(fg);
    c.bg           = COLOR_W'(bg);
    return c;
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int roll;
    c = make_cmd(OP_PUT, $urandom, 1'b0, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 15) == 0) begin
      c.fg = '0;
      c.bg = '0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      if ($urandom_range(0, 19) == 0) c.character = CHAR_NEWLINE;
    end else if (roll < 70) begin
      c.use_position = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        c.row = ROW_W'($urandom_range(0, ROWS - 1));
        c.col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
      if ($urandom_range(0, 9) == 0) c.character = CHAR_NEWLINE;
    end else if (roll < 96) begin
      c.op = OP_READ;
      c.use_position = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) != 0) begin
        c.row = ROW_W'($urandom_range(0, ROWS - 1));
        c.col = COL_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (roll < 97) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_NONE;
    end
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $time, result_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result();
    console_result_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      report_mismatch("item arrived with nothing expected");
      return;
    end
    want = pending_results.pop_front();
    check_field("cursor_row", 8'(out_if.cursor_row), 8'(want.cursor_row));
    check_field("cursor_col", 8'(out_if.cursor_col), 8'(want.cursor_col));
    check_field("scrolled", 8'(out_if.scrolled), 8'(want.scrolled));
    check_field("cell_char", out_if.cell_char, want.cell_char);
    check_field("cell_attr", out_if.cell_attr, want.cell_attr);
  endtask

  // Result side: random stalls plus a counted hold-off on request
  initial begin : result_sink
    int idle_left;
    idle_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) check_result();
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_if.ready <= 1'b0;
      end else if (stall_enable && idle_left > 0) begin
        idle_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (stall_enable && $urandom_range(0, 3) == 0) idle_left = pick_gap();
      end
    end
  end

  task automatic send_command(console_cmd_t c);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.op           <= c.op;
    in_if.character    <= c.character;
    in_if.use_position <= c.use_position;
    in_if.row          <= c.row;
    in_if.col          <= c.col;
    in_if.fg           <= c.fg;
    in_if.bg           <= c.bg;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(apply_command(c));
    if (sender_gaps) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and hold until every result is back and the block takes input again
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DEFAULT_FG) dflt_fg = value;
    else dflt_bg = value;
    @(posedge clk);
  endtask

  task automatic test_reset_contents();
    send_command(make_cmd(OP_READ, 0, 1'b1, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b0, ROWS - 1, COLUMNS - 1, 0, 0));
  endtask

  task automatic test_put_extremes();
    send_command(make_cmd(OP_PUT, 8'hff, 1'b0, 0, 0, 15, 15));
    send_command(make_cmd(OP_PUT, 8'h00, 1'b0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, 0, 1, 0, 0));
  endtask

  task automatic test_newline_and_none();
    send_command(make_cmd(OP_PUT, CHAR_NEWLINE, 1'b0, 0, 0, 7, 1));
    send_command(make_cmd(OP_NONE, 8'hff, 1'b1, 31, 127, 15, 15));
    send_command(make_cmd(OP_PUT, CHAR_NEWLINE, 1'b1, 5, 40, 2, 3));
  endtask

  task automatic test_clamp_and_scroll();
    // clamped to the last cell, so the put itself scrolls
    send_command(make_cmd(OP_PUT, "A", 1'b1, 31, 127, 4, 2));
    send_command(make_cmd(OP_READ, 0, 1'b1, ROWS - 2, COLUMNS - 1, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, ROWS - 1, COLUMNS - 1, 0, 0));
    send_command(make_cmd(OP_PUT, CHAR_NEWLINE, 1'b1, ROWS - 1, 3, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, ROWS - 3, 127, 0, 0));
  endtask

  task automatic test_default_colors();
    wait_idle();
    write_register(CFG_DEFAULT_FG, 4'h0);
    write_register(CFG_DEFAULT_BG, 4'h0);
    send_command(make_cmd(OP_PUT, "z", 1'b1, 2, 2, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, 2, 2, 0, 0));
    send_command(make_cmd(OP_PUT, CHAR_NEWLINE, 1'b1, 30, 0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, ROWS - 1, 0, 0, 0));
    wait_idle();
    write_register(CFG_DEFAULT_FG, 4'hf);
    write_register(CFG_DEFAULT_BG, 4'hf);
    send_command(make_cmd(OP_CLEAR, 0, 1'b0, 0, 0, 0, 0));
    send_command(make_cmd(OP_READ, 0, 1'b1, 12, 40, 0, 0));
    wait_idle();
    write_register(CFG_DEFAULT_FG, DEF_FG_RST);
    write_register(CFG_DEFAULT_BG, DEF_BG_RST);
  endtask

  task automatic test_backpressure();
    wait_idle();
    sender_gaps = 1'b0;
    hold_off_cycles = 400;
    repeat (8) send_command(make_cmd(OP_PUT, $urandom, 1'b0, 0, 0, $urandom, $urandom));
    sender_gaps = 1'b1;
  endtask

  task automatic run_random_items(int n);
    int sent;
    int burst;
    console_cmd_t c;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 99) < 3) begin
        // park near the end of the last row, then type past it
        send_command(make_cmd(OP_PUT, $urandom, 1'b1, ROWS - 1,
                              $urandom_range(COLUMNS - 10, COLUMNS - 1), $urandom, $urandom));
        burst = $urandom_range(4, 12);
        repeat (burst) begin
          c = random_command();
          c.op = OP_PUT;
          c.use_position = 1'b0;
          send_command(c);
        end
        sent += burst + 1;
      end else begin
        send_command(random_command());
        sent++;
      end
    end
  endtask

  task automatic test_random_phases();
    logic [COLOR_W-1:0] f;
    logic [COLOR_W-1:0] b;
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          f = DEF_FG_RST;
          b = DEF_BG_RST;
        end
        1: begin
          f = 4'h0;
          b = 4'h0;
        end
        2: begin
          f = 4'hf;
          b = 4'hf;
        end
        default: begin
          f = COLOR_W'($urandom);
          b = COLOR_W'($urandom);
        end
      endcase
      write_register(CFG_DEFAULT_FG, f);
      write_register(CFG_DEFAULT_BG, b);
      sender_gaps  = (ph != 2);
      stall_enable = (ph != 2);
      run_random_items(300);
    end
  endtask

  initial begin
    in_if.valid        <= 1'b0;
    in_if.op           <= OP_PUT;
    in_if.character    <= '0;
    in_if.use_position <= 1'b0;
    in_if.row          <= '0;
    in_if.col          <= '0;
    in_if.fg           <= '0;
    in_if.bg           <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_DEFAULT_FG;
    cfg_wdata          <= '0;
    rst_n              <= 1'b0;
    error_count     = 0;
    result_count    = 0;
    hold_off_cycles = 0;
    sender_gaps     = 1'b1;
    stall_enable    = 1'b1;
    dflt_fg         = DEF_FG_RST;
    dflt_bg         = DEF_BG_RST;
    blank_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_contents();
    test_put_extremes();
    test_newline_and_none();
    test_clamp_and_scroll();
    test_default_colors();
    test_backpressure();
    test_random_phases();

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[text_console_writer_top.f]
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/text_console_writer_top.sv
test/text_console_writer_top_tb.sv
